>>> rtl/core/assert_macros.svh
// Assertion wrappers, compiled out with NO_ASSERTIONS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ACD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ACD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ACD_ASSERT(lbl, clk, rstn, prop)
`define ACD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/core/acd_pkg.sv
package acd_pkg;

    localparam int COORD_W   = 24;
    localparam int REL_W     = 25;
    localparam int DIFF_W    = 26;
    localparam int SQ_W      = 52;
    localparam int TYPE_W    = 4;
    localparam int SRC_W     = 8;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int STATUS_W  = 2;
    localparam int DIST_LAT  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ABS_TYPE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ABS_OCC  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COINCIDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE    = 3'd4;

    localparam logic [CFG_W-1:0] RST_CUTOFF   = 48'd429496729600;
    localparam logic [CFG_W-1:0] RST_COINCIDE = 48'd42949673;
    localparam logic [CFG_W-1:0] RST_CLOSE    = 48'd3683321000;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_ABS = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MULTI  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_OVF    = 2'd3;

    typedef struct packed {
        logic signed [REL_W-1:0] z;
        logic signed [REL_W-1:0] y;
        logic signed [REL_W-1:0] x;
    } t_vec3;

    typedef struct packed {
        t_vec3             rel;
        logic [TYPE_W-1:0] etype;
        logic [SRC_W-1:0]  src;
        logic [SQ_W-1:0]   r2;
    } t_entry;

    typedef enum logic [4:0] {
        S_LOAD,
        S_SCAN,
        S_ABS_RD,
        S_ABS_WT,
        S_BUILD,
        S_BDRAIN,
        S_SORT_RD,
        S_SWAP_A,
        S_SWAP_B,
        S_PAIR_RD,
        S_PAIR_LAT,
        S_PAIR_RUN,
        S_PAIR_DRAIN,
        S_EMIT_RD,
        S_EMIT_WT,
        S_ERR
    } t_state;

endpackage

>>> rtl/core/acd_ram.sv
module acd_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/acd_dist.sv
module acd_dist #(
    parameter int TAG_W = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  acd_pkg::t_vec3                      i_a,
    input  acd_pkg::t_vec3                      i_b,
    input  logic [TAG_W-1:0]                    i_tag,
    output logic                                o_vld,
    output logic [acd_pkg::SQ_W-1:0]            o_d2,
    output logic signed [acd_pkg::DIFF_W-1:0]   o_dx,
    output logic signed [acd_pkg::DIFF_W-1:0]   o_dy,
    output logic signed [acd_pkg::DIFF_W-1:0]   o_dz,
    output logic [TAG_W-1:0]                    o_tag
);

    logic [2:0] r_vld;
    logic signed [acd_pkg::DIFF_W-1:0] r_dx1, r_dy1, r_dz1;
    logic signed [acd_pkg::DIFF_W-1:0] r_dx2, r_dy2, r_dz2;
    logic signed [acd_pkg::DIFF_W-1:0] r_dx3, r_dy3, r_dz3;
    logic [acd_pkg::SQ_W-1:0] r_sx, r_sy, r_sz, r_d2;
    logic [TAG_W-1:0] r_tag1, r_tag2, r_tag3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx1  <= acd_pkg::DIFF_W'(i_a.x) - acd_pkg::DIFF_W'(i_b.x);
        r_dy1  <= acd_pkg::DIFF_W'(i_a.y) - acd_pkg::DIFF_W'(i_b.y);
        r_dz1  <= acd_pkg::DIFF_W'(i_a.z) - acd_pkg::DIFF_W'(i_b.z);
        r_tag1 <= i_tag;

        r_sx   <= r_dx1 * r_dx1;
        r_sy   <= r_dy1 * r_dy1;
        r_sz   <= r_dz1 * r_dz1;
        r_dx2  <= r_dx1;
        r_dy2  <= r_dy1;
        r_dz2  <= r_dz1;
        r_tag2 <= r_tag1;

        r_d2   <= r_sx + r_sy + r_sz;
        r_dx3  <= r_dx2;
        r_dy3  <= r_dy2;
        r_dz3  <= r_dz2;
        r_tag3 <= r_tag2;
    end

    assign o_vld = r_vld[2];
    assign o_d2  = r_d2;
    assign o_dx  = r_dx3;
    assign o_dy  = r_dy3;
    assign o_dz  = r_dz3;
    assign o_tag = r_tag3;

endmodule

>>> rtl/core/atom_cluster_distance_sort.sv
// Atoms load at one per cycle while the block waits for input; an atom
// without tlast gives no result. After the last atom: absorber scan, filter,
// selection sort and pair check, then the results go out one by one; one run
// at a time, as input is accepted only in the load state.
// Synchronous active-low reset clears control state and sets configuration to
// its defaults; atom and cluster memories are not cleared.
`include "assert_macros.svh"

module atom_cluster_distance_sort #(
    parameter int MAX_INPUT_ATOMS = 256,
    parameter int MAX_CLUSTER     = 64,
    parameter int NUM_TYPES       = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // pos_x, pos_y, pos_z
    input  logic [3:0]  s_axis_tuser,   // atom_type
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // rel_x, rel_y, rel_z, source_index, highest_type
    output logic [7:0]  m_axis_tuser,   // entry_type, model_atom, too_close, status
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    localparam int AW     = $clog2(MAX_INPUT_ATOMS);
    localparam int NW     = AW + 1;
    localparam int CW     = $clog2(MAX_CLUSTER);
    localparam int KW     = CW + 1;
    localparam int OW     = (NW > 8) ? NW : 8;
    localparam int TW     = acd_pkg::TYPE_W;
    localparam int TAG_W  = TW + AW;
    localparam int ATOM_W = 3 * acd_pkg::COORD_W + TW;
    localparam int EW     = $bits(acd_pkg::t_entry);
    localparam int SW     = acd_pkg::SQ_W;

    acd_pkg::t_state r_state, n_state;

    logic [TW-1:0]               r_abs_type;
    logic [7:0]                  r_abs_occ;
    logic [acd_pkg::CFG_W-1:0]   r_cut, r_coin, r_close_sq;

    logic [NW-1:0] r_n, r_idx, r_acnt;
    logic          r_pend, r_found, r_ovf;
    logic [AW-1:0] r_ptag, r_abs;
    acd_pkg::t_vec3 r_abs_pos;

    logic [KW-1:0] r_ccnt, r_i, r_j, r_k, r_ctag, r_bi;
    logic          r_cpend;
    acd_pkg::t_entry r_cur, r_best;
    logic [MAX_CLUSTER-1:0] r_close;
    logic [15:0]   r_seen;
    logic [1:0]    r_wait;
    logic [TW-1:0] r_highest;
    logic [acd_pkg::STATUS_W-1:0] r_err;

    logic        r_ov, r_o_tlast;
    logic [87:0] r_o_tdata;
    logic [7:0]  r_o_tuser;

    logic              s_fire, out_free;
    logic              a_we, a_re;
    logic [AW-1:0]     a_raddr;
    logic [ATOM_W-1:0] a_rdata;
    logic signed [acd_pkg::COORD_W-1:0] a_x, a_y, a_z;
    logic [TW-1:0]     a_t, a_tm;

    logic              c_we, c_re;
    logic [CW-1:0]     c_waddr, c_raddr;
    acd_pkg::t_entry   c_wdata, c_rdata;
    logic [EW-1:0]     c_rbits;

    logic              d_vld, d_ovld;
    acd_pkg::t_vec3    d_a, d_b;
    logic [TAG_W-1:0]  d_tag, d_otag;
    logic [SW-1:0]     d_d2;
    logic signed [acd_pkg::DIFF_W-1:0] d_dx, d_dy, d_dz;
    logic [TW-1:0]     d_otype;

    logic [NW-1:0]     acnt_inc;
    logic              keep, pair_hit, model;
    logic [KW-1:0]     i_plus2;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == acd_pkg::S_LOAD);
    assign o_cfg_ready   = 1'b1;

    assign a_we = s_fire && (r_n < NW'(MAX_INPUT_ATOMS));
    assign a_x  = a_rdata[23:0];
    assign a_y  = a_rdata[47:24];
    assign a_z  = a_rdata[71:48];
    assign a_t  = a_rdata[75:72];
    assign a_tm = (a_t == '0) ? r_abs_type : a_t;

    assign c_rdata  = c_rbits;
    assign acnt_inc = r_acnt + NW'(1);
    assign i_plus2  = r_i + KW'(2);
    assign d_otype  = d_otag[TAG_W-1:AW];
    assign keep     = d_ovld && (d_d2 > SW'(r_coin)) && (d_d2 <= SW'(r_cut));
    assign pair_hit = d_ovld && (d_d2 < SW'(r_close_sq));
    assign model    = (r_k == '0) || ((c_rdata.etype != '0)
                      && ({1'b0, c_rdata.etype} < 5'(NUM_TYPES))
                      && !r_seen[c_rdata.etype]);

    acd_ram #(.WIDTH(ATOM_W), .DEPTH(MAX_INPUT_ATOMS)) u_atom_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (r_n[AW-1:0]),
        .i_wdata ({s_axis_tuser, s_axis_tdata}),
        .i_re    (a_re),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    acd_ram #(.WIDTH(EW), .DEPTH(MAX_CLUSTER)) u_clu_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (c_rbits)
    );

    acd_dist #(.TAG_W(TAG_W)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (d_vld),
        .i_a     (d_a),
        .i_b     (d_b),
        .i_tag   (d_tag),
        .o_vld   (d_ovld),
        .o_d2    (d_d2),
        .o_dx    (d_dx),
        .o_dy    (d_dy),
        .o_dz    (d_dz),
        .o_tag   (d_otag)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            acd_pkg::S_LOAD: begin
                if (s_fire && s_axis_tlast) n_state = acd_pkg::S_SCAN;
            end
            acd_pkg::S_SCAN: begin
                if (r_idx == r_n && !r_pend) begin
                    if (!r_found) begin
                        n_state = acd_pkg::S_ERR;
                    end else if (r_abs_type == '0 && r_acnt > NW'(1)) begin
                        n_state = acd_pkg::S_ERR;
                    end else begin
                        n_state = acd_pkg::S_ABS_RD;
                    end
                end
            end
            acd_pkg::S_ABS_RD: n_state = acd_pkg::S_ABS_WT;
            acd_pkg::S_ABS_WT: n_state = acd_pkg::S_BUILD;
            acd_pkg::S_BUILD: begin
                if (r_idx == r_n && !r_pend) n_state = acd_pkg::S_BDRAIN;
            end
            acd_pkg::S_BDRAIN: begin
                if (r_wait == 2'(acd_pkg::DIST_LAT)) begin
                    if (r_ovf) begin
                        n_state = acd_pkg::S_ERR;
                    end else if (r_ccnt >= KW'(2)) begin
                        n_state = acd_pkg::S_SORT_RD;
                    end else begin
                        n_state = acd_pkg::S_EMIT_RD;
                    end
                end
            end
            acd_pkg::S_SORT_RD: begin
                if (r_j == r_ccnt && !r_cpend) begin
                    if (r_bi != r_i) begin
                        n_state = acd_pkg::S_SWAP_A;
                    end else if (i_plus2 < r_ccnt) begin
                        n_state = acd_pkg::S_SORT_RD;
                    end else begin
                        n_state = acd_pkg::S_PAIR_RD;
                    end
                end
            end
            acd_pkg::S_SWAP_A: n_state = acd_pkg::S_SWAP_B;
            acd_pkg::S_SWAP_B: begin
                n_state = (i_plus2 < r_ccnt) ? acd_pkg::S_SORT_RD : acd_pkg::S_PAIR_RD;
            end
            acd_pkg::S_PAIR_RD:  n_state = acd_pkg::S_PAIR_LAT;
            acd_pkg::S_PAIR_LAT: n_state = acd_pkg::S_PAIR_RUN;
            acd_pkg::S_PAIR_RUN: begin
                if (r_j == r_ccnt && !r_cpend) n_state = acd_pkg::S_PAIR_DRAIN;
            end
            acd_pkg::S_PAIR_DRAIN: begin
                if (r_wait == 2'(acd_pkg::DIST_LAT)) begin
                    n_state = (i_plus2 < r_ccnt) ? acd_pkg::S_PAIR_RD : acd_pkg::S_EMIT_RD;
                end
            end
            acd_pkg::S_EMIT_RD: n_state = acd_pkg::S_EMIT_WT;
            acd_pkg::S_EMIT_WT: begin
                if (out_free) begin
                    n_state = (r_k + KW'(1) == r_ccnt) ? acd_pkg::S_LOAD
                                                        : acd_pkg::S_EMIT_RD;
                end
            end
            acd_pkg::S_ERR: begin
                if (out_free) n_state = acd_pkg::S_LOAD;
            end
            default: n_state = acd_pkg::S_LOAD;
        endcase
    end

    always_comb begin
        a_re    = 1'b0;
        a_raddr = r_idx[AW-1:0];
        c_re    = 1'b0;
        c_raddr = r_j[CW-1:0];
        c_we    = 1'b0;
        c_waddr = r_ccnt[CW-1:0];
        c_wdata = '{rel: '{x: d_dx[24:0], y: d_dy[24:0], z: d_dz[24:0]},
                    etype: d_otype, src: 8'(d_otag[AW-1:0]), r2: d_d2};
        d_vld   = 1'b0;
        d_a     = '{x: 25'(a_x), y: 25'(a_y), z: 25'(a_z)};
        d_b     = r_abs_pos;
        d_tag   = {a_tm, r_ptag};
        unique case (r_state)
            acd_pkg::S_SCAN: begin
                a_re = (r_idx < r_n);
            end
            acd_pkg::S_ABS_RD: begin
                a_re    = 1'b1;
                a_raddr = r_abs;
            end
            acd_pkg::S_ABS_WT: begin
                c_we    = 1'b1;
                c_waddr = '0;
                c_wdata = '{rel: '0, etype: '0, src: 8'(r_abs), r2: '0};
            end
            acd_pkg::S_BUILD, acd_pkg::S_BDRAIN: begin
                a_re  = (r_state == acd_pkg::S_BUILD) && (r_idx < r_n);
                d_vld = (r_state == acd_pkg::S_BUILD) && r_pend && (r_ptag != r_abs);
                c_we  = keep && !r_ovf && (r_ccnt < KW'(MAX_CLUSTER));
            end
            acd_pkg::S_SORT_RD: begin
                c_re = (r_j < r_ccnt);
            end
            acd_pkg::S_SWAP_A: begin
                c_we    = 1'b1;
                c_waddr = r_i[CW-1:0];
                c_wdata = r_best;
            end
            acd_pkg::S_SWAP_B: begin
                c_we    = 1'b1;
                c_waddr = r_bi[CW-1:0];
                c_wdata = r_cur;
            end
            acd_pkg::S_PAIR_RD: begin
                c_re    = 1'b1;
                c_raddr = r_i[CW-1:0];
            end
            acd_pkg::S_PAIR_RUN: begin
                c_re  = (r_j < r_ccnt);
                d_vld = r_cpend;
                d_a   = c_rdata.rel;
                d_b   = r_cur.rel;
                d_tag = TAG_W'(r_ctag);
            end
            acd_pkg::S_EMIT_RD: begin
                c_re    = 1'b1;
                c_raddr = r_k[CW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acd_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_type <= '0;
            r_abs_occ  <= '0;
            r_cut      <= acd_pkg::RST_CUTOFF;
            r_coin     <= acd_pkg::RST_COINCIDE;
            r_close_sq <= acd_pkg::RST_CLOSE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                acd_pkg::CFG_ABS_TYPE: r_abs_type <= i_cfg_data[TW-1:0];
                acd_pkg::CFG_ABS_OCC:  r_abs_occ  <= i_cfg_data[7:0];
                acd_pkg::CFG_CUTOFF:   r_cut      <= i_cfg_data;
                acd_pkg::CFG_COINCIDE: r_coin     <= i_cfg_data;
                acd_pkg::CFG_CLOSE:    r_close_sq <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n       <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_cpend   <= 1'b0;
            r_found   <= 1'b0;
            r_acnt    <= '0;
            r_ovf     <= 1'b0;
            r_ccnt    <= '0;
            r_wait    <= '0;
            r_err     <= acd_pkg::STAT_OK;
            r_ov      <= 1'b0;
            r_close   <= '0;
            r_seen    <= '0;
        end else begin
            r_pend  <= a_re && (r_state != acd_pkg::S_ABS_RD);
            r_cpend <= c_re && (r_state == acd_pkg::S_SORT_RD
                                || r_state == acd_pkg::S_PAIR_RUN);
            if (m_axis_tready) r_ov <= 1'b0;
            if (a_re && r_state != acd_pkg::S_ABS_RD) r_idx <= r_idx + NW'(1);

            unique case (r_state)
                acd_pkg::S_LOAD: begin
                    if (a_we) r_n <= r_n + NW'(1);
                    if (s_fire && s_axis_tlast) begin
                        r_idx   <= '0;
                        r_acnt  <= '0;
                        r_found <= 1'b0;
                    end
                end
                acd_pkg::S_SCAN: begin
                    if (r_pend && a_tm == r_abs_type) begin
                        r_acnt <= acnt_inc;
                        if (!r_found && (OW'(acnt_inc) == OW'(r_abs_occ)
                            || (r_abs_occ == '0 && acnt_inc == NW'(1)))) begin
                            r_found <= 1'b1;
                        end
                    end
                    if (n_state == acd_pkg::S_ERR) begin
                        r_err <= r_found ? acd_pkg::STAT_MULTI : acd_pkg::STAT_NO_ABS;
                    end
                end
                acd_pkg::S_ABS_WT: begin
                    r_idx   <= '0;
                    r_ccnt  <= KW'(1);
                    r_ovf   <= 1'b0;
                    r_close <= '0;
                    r_seen  <= '0;
                    r_wait  <= '0;
                end
                acd_pkg::S_BUILD, acd_pkg::S_BDRAIN: begin
                    if (keep && !r_ovf) begin
                        if (r_ccnt >= KW'(MAX_CLUSTER)) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_ccnt <= r_ccnt + KW'(1);
                        end
                    end
                    if (r_state == acd_pkg::S_BDRAIN) r_wait <= r_wait + 2'd1;
                    if (n_state == acd_pkg::S_ERR) r_err <= acd_pkg::STAT_OVF;
                end
                acd_pkg::S_PAIR_RUN: begin
                    r_wait <= '0;
                end
                acd_pkg::S_PAIR_DRAIN: begin
                    r_wait <= r_wait + 2'd1;
                    if (n_state != acd_pkg::S_PAIR_DRAIN) r_wait <= '0;
                end
                acd_pkg::S_EMIT_WT: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        if (r_k != '0) r_seen[c_rdata.etype] <= 1'b1;
                        if (n_state == acd_pkg::S_LOAD) r_n <= '0;
                    end
                end
                acd_pkg::S_ERR: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        r_n  <= '0;
                    end
                end
                default: begin
                end
            endcase

            if (pair_hit && (r_state == acd_pkg::S_PAIR_RUN
                             || r_state == acd_pkg::S_PAIR_DRAIN)) begin
                r_close[r_i[CW-1:0]]    <= 1'b1;
                r_close[d_otag[CW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == acd_pkg::S_SCAN && r_pend && a_tm == r_abs_type && !r_found
            && (OW'(acnt_inc) == OW'(r_abs_occ)
                || (r_abs_occ == '0 && acnt_inc == NW'(1)))) begin
            r_abs <= r_ptag;
        end
        if (a_re) r_ptag <= r_idx[AW-1:0];
        if (c_re) r_ctag <= c_raddr == r_j[CW-1:0] ? r_j : r_i;

        unique case (r_state)
            acd_pkg::S_ABS_WT: begin
                r_abs_pos <= '{x: 25'(a_x), y: 25'(a_y), z: 25'(a_z)};
                r_highest <= '0;
                r_k       <= '0;
                r_i       <= '0;
                r_j       <= '0;
            end
            acd_pkg::S_BUILD, acd_pkg::S_BDRAIN: begin
                if (c_we && d_otype != '0 && {1'b0, d_otype} < 5'(NUM_TYPES)
                    && d_otype > r_highest) begin
                    r_highest <= d_otype;
                end
            end
            acd_pkg::S_SORT_RD: begin
                if (c_re) r_j <= r_j + KW'(1);
                if (r_cpend) begin
                    if (r_ctag == r_i) begin
                        r_cur  <= c_rdata;
                        r_best <= c_rdata;
                        r_bi   <= r_i;
                    end else if (c_rdata.r2 < r_best.r2) begin
                        r_best <= c_rdata;
                        r_bi   <= r_ctag;
                    end
                end
                if (r_j == r_ccnt && !r_cpend && r_bi == r_i) begin
                    r_i <= (n_state == acd_pkg::S_PAIR_RD) ? '0 : r_i + KW'(1);
                    r_j <= r_i + KW'(1);
                end
            end
            acd_pkg::S_SWAP_B: begin
                r_i <= (n_state == acd_pkg::S_PAIR_RD) ? '0 : r_i + KW'(1);
                r_j <= r_i + KW'(1);
            end
            acd_pkg::S_PAIR_LAT: begin
                r_cur <= c_rdata;
                r_j   <= r_i + KW'(1);
            end
            acd_pkg::S_PAIR_RUN: begin
                if (c_re) r_j <= r_j + KW'(1);
            end
            acd_pkg::S_PAIR_DRAIN: begin
                if (n_state != acd_pkg::S_PAIR_DRAIN) r_i <= r_i + KW'(1);
            end
            acd_pkg::S_EMIT_WT: begin
                if (out_free) begin
                    r_k       <= r_k + KW'(1);
                    r_o_tdata <= {1'b0, r_highest, c_rdata.src, c_rdata.rel};
                    r_o_tuser <= {acd_pkg::STAT_OK, r_close[r_k[CW-1:0]], model,
                                  c_rdata.etype};
                    r_o_tlast <= (r_k + KW'(1) == r_ccnt);
                end
            end
            acd_pkg::S_ERR: begin
                if (out_free) begin
                    r_o_tdata <= '0;
                    r_o_tuser <= {r_err, 6'd0};
                    r_o_tlast <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_o_tdata;
    assign m_axis_tuser  = r_o_tuser;
    assign m_axis_tlast  = r_o_tlast;

    `ACD_ASSERT(a_ccnt_max, i_clk, i_rst_n, r_ccnt <= KW'(MAX_CLUSTER))
    `ACD_ASSERT(a_build_found, i_clk, i_rst_n, (r_state == acd_pkg::S_BUILD) |-> r_found)
    `ACD_ASSERT(a_swap_closer, i_clk, i_rst_n, (r_state == acd_pkg::S_SWAP_A) |-> (r_best.r2 < r_cur.r2))
    `ACD_ASSERT(a_err_last, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser[7:6] != acd_pkg::STAT_OK) |-> m_axis_tlast)
    `ACD_ASSERT_NEXT(a_swap_pair, i_clk, i_rst_n, r_state == acd_pkg::S_SWAP_A, c_rdata == c_rdata && r_state == acd_pkg::S_SWAP_B)

endmodule
